FILE: hdl/three_wire_rtc_serial_master_defines.svh
// Assertion macros used by the checker file.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TWRTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("three-wire master check failed");

// Next-cycle implication, checked out of reset.
`define TWRTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("three-wire master check failed");

`endif

FILE: hdl/twrtc_pkg.sv
package twrtc_pkg;

  // Request codes carried by each tick
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
  localparam logic [3:0] LAST_WRITE_BIT    = 4'd15;
  localparam logic [3:0] LAST_READ_BIT     = 4'd7;

  // Pin sequencer phases
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_LOW    = 7'b0000010,
    PH_HIGH   = 7'b0000100,
    PH_TAIL   = 7'b0001000,
    PH_SETTLE = 7'b0010000,
    PH_RHIGH  = 7'b0100000,
    PH_RLOW   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       io_in;
  } in_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_item_t;

endpackage

FILE: hdl/three_wire_rtc_serial_master.sv
// Three-wire serial master for a real-time clock chip. Every input transaction is one
// sequencer tick carrying the sampled data pin level, and yields exactly one result
// transaction with the pin levels after that tick. An idle tick with req_type write or
// read starts a serial transfer (address byte LSB first, then data byte or 8 sampled
// bits); requests seen while busy are dropped. One tick is accepted every clock cycle while
// the output is not stalled: the next-state logic sits between the phase/shift registers and a
// single output register, so a result appears in the cycle after its tick and the input stays
// ready while the output register is empty or being drained. half_r is written through the
// cfg_ port and sets the number of ticks per clock level and settle delay.
module three_wire_rtc_serial_master
  import twrtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [15:0] out_shift_r, out_shift_nxt;
  logic [7:0] in_shift_r, in_shift_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] last_read_r, last_read_nxt;
  logic [7:0] half_r;
  logic       done;
  logic       in_fire;
  logic       out_valid_r;
  out_item_t  out_data_r, res;
  logic [7:0] sample_shift;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sample_shift = {in_data.io_in, in_shift_r[7:1]};

  // Sequencer next state for one tick
  always_comb begin
    phase_nxt     = phase_r;
    bit_idx_nxt   = bit_idx_r;
    tick_nxt      = tick_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    is_read_nxt   = is_read_r;
    last_read_nxt = last_read_r;
    done          = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (in_data.req_type == REQ_WRITE || in_data.req_type == REQ_READ) begin
        is_read_nxt   = (in_data.req_type == REQ_READ);
        out_shift_nxt = (in_data.req_type == REQ_READ) ? {8'd0, in_data.address}
                                                       : {in_data.write_data, in_data.address};
        in_shift_nxt  = 8'd0;
        bit_idx_nxt   = 4'd0;
        tick_nxt      = 8'd1;
        phase_nxt     = PH_LOW;
      end
    end else if (tick_r < half_r) begin
      tick_nxt = tick_r + 8'd1;
    end else begin
      tick_nxt = 8'd1;
      case (phase_r)
        PH_LOW: begin
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          if (is_read_r && bit_idx_r >= LAST_READ_BIT) begin
            bit_idx_nxt = 4'd0;
            phase_nxt   = PH_SETTLE;
          end else if (!is_read_r && bit_idx_r >= LAST_WRITE_BIT) begin
            phase_nxt = PH_TAIL;
          end else begin
            bit_idx_nxt   = bit_idx_r + 4'd1;
            out_shift_nxt = {1'b0, out_shift_r[15:1]};
            phase_nxt     = PH_LOW;
          end
        end
        PH_TAIL: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_SETTLE: begin
          in_shift_nxt = sample_shift;
          bit_idx_nxt  = 4'd1;
          phase_nxt    = PH_RHIGH;
        end
        PH_RHIGH: begin
          phase_nxt = PH_RLOW;
        end
        PH_RLOW: begin
          in_shift_nxt = sample_shift;
          if (bit_idx_r >= LAST_READ_BIT) begin
            last_read_nxt = sample_shift;
            phase_nxt     = PH_IDLE;
            done          = 1'b1;
          end else begin
            bit_idx_nxt = bit_idx_r + 4'd1;
            phase_nxt   = PH_RHIGH;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Pin levels after this tick
  always_comb begin
    res              = '0;
    res.chip_enable  = (phase_nxt != PH_IDLE);
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.serial_clock = (phase_nxt == PH_IDLE) || (phase_nxt == PH_HIGH) ||
                       (phase_nxt == PH_RHIGH);
    res.io_drive     = (phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH) ||
                       (phase_nxt == PH_TAIL);
    res.io_out       = res.io_drive && out_shift_nxt[0];
    res.done_res     = done;
    res.read_data    = last_read_nxt;
  end

  // Sequencer state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_idx_r   <= 4'd0;
      tick_r      <= 8'd0;
      out_shift_r <= 16'd0;
      in_shift_r  <= 8'd0;
      is_read_r   <= 1'b0;
      last_read_r <= 8'd0;
      half_r      <= HALF_PERIOD_RESET;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        bit_idx_r   <= bit_idx_nxt;
        tick_r      <= tick_nxt;
        out_shift_r <= out_shift_nxt;
        in_shift_r  <= in_shift_nxt;
        is_read_r   <= is_read_nxt;
        last_read_r <= last_read_nxt;
      end
      if (cfg_valid) begin
        half_r <= cfg_data;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: hdl/twrtc_checker.sv
`include "three_wire_rtc_serial_master_defines.svh"

module twrtc_checker
  import twrtc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic idle_lines_ok;

  // Idle lines: clock high, enable low, pin released
  assign idle_lines_ok = out_data.serial_clock && !out_data.chip_enable &&
                         !out_data.io_drive;

  // Stalled result holds
  `TWRTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // Done pulse coincides with return to idle
  `TWRTC_ASSERT_NOW(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res)
  // Idle result shows idle lines
  `TWRTC_ASSERT_NOW(a_idle_lines, out_valid && !out_data.busy_res, idle_lines_ok)
  // Data pin only shows a level while driven
  `TWRTC_ASSERT_NOW(a_io_driven, out_valid && out_data.io_out, out_data.io_drive)

endmodule

bind three_wire_rtc_serial_master twrtc_checker u_twrtc_checker (.*);

FILE: tb/three_wire_rtc_serial_master_tb.sv
module three_wire_rtc_serial_master_tb;
  import twrtc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Level of the sampled data pin on filler ticks
  localparam int IO_LOW    = 0;
  localparam int IO_HIGH   = 1;
  localparam int IO_RANDOM = 2;

  // Idle/stall percentages per phase
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_ONE   = 65;
  localparam int IDLE_BOTH  = 31;

  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  three_wire_rtc_serial_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  in_item_t  tick_q[$];        // ticks waiting to be sent
  out_item_t pin_levels_q[$];  // predicted pin levels, oldest first
  int        send_idle_pct  = IDLE_NONE;
  int        recv_stall_pct = IDLE_NONE;
  int        mismatch_cnt   = 0;
  int        result_cnt     = 0;
  int        stall_cycles   = 0;
  out_item_t want;

  // Sequencer copy kept by the testbench
  logic [7:0]  half_ticks = HALF_PERIOD_RESET;
  phase_t      seq_phase  = PH_IDLE;
  logic [4:0]  seq_bit    = '0;
  logic [7:0]  seq_ticks  = '0;
  logic [15:0] tx_bits    = '0;
  logic [7:0]  rx_bits    = '0;
  logic        seq_read   = 1'b0;
  logic [7:0]  last_byte  = '0;

  // One sequencer tick: advance the phase machine, return the pin levels after it
  function automatic out_item_t advance_sequencer(in_item_t t);
    out_item_t r;
    logic      done;
    done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (t.req_type == REQ_WRITE || t.req_type == REQ_READ) begin
        seq_read  = (t.req_type == REQ_READ);
        tx_bits   = seq_read ? {8'h00, t.address} : {t.write_data, t.address};
        rx_bits   = '0;
        seq_bit   = '0;
        seq_ticks = 8'd1;
        seq_phase = PH_LOW;
      end
    end else if (seq_ticks < half_ticks) begin
      seq_ticks = seq_ticks + 8'd1;
    end else begin
      seq_ticks = 8'd1;
      case (seq_phase)
        PH_LOW: seq_phase = PH_HIGH;
        PH_HIGH: begin
          if (seq_read && seq_bit >= LAST_READ_BIT) begin
            seq_bit   = '0;
            seq_phase = PH_SETTLE;
          end else if (!seq_read && seq_bit >= LAST_WRITE_BIT) begin
            seq_phase = PH_TAIL;
          end else begin
            seq_bit   = seq_bit + 5'd1;
            tx_bits   = tx_bits >> 1;
            seq_phase = PH_LOW;
          end
        end
        PH_TAIL: begin
          seq_phase = PH_IDLE;
          done      = 1'b1;
        end
        PH_SETTLE: begin
          rx_bits   = {t.io_in, rx_bits[7:1]};
          seq_bit   = 5'd1;
          seq_phase = PH_RHIGH;
        end
        PH_RHIGH: seq_phase = PH_RLOW;
        PH_RLOW: begin
          // samples enter at the top, first one ends in bit 0
          rx_bits = {t.io_in, rx_bits[7:1]};
          if (seq_bit >= LAST_READ_BIT) begin
            last_byte = rx_bits;
            seq_phase = PH_IDLE;
            done      = 1'b1;
          end else begin
            seq_bit   = seq_bit + 5'd1;
            seq_phase = PH_RHIGH;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    r.chip_enable  = (seq_phase != PH_IDLE);
    r.serial_clock = (seq_phase == PH_IDLE || seq_phase == PH_HIGH || seq_phase == PH_RHIGH);
    r.io_drive     = (seq_phase == PH_LOW || seq_phase == PH_HIGH || seq_phase == PH_TAIL);
    r.io_out       = r.io_drive & tx_bits[0];
    r.busy_res     = r.chip_enable;
    r.done_res     = done;
    r.read_data    = last_byte;
    return r;
  endfunction

  function automatic in_item_t make_tick(logic [1:0] req, logic [7:0] addr,
                                         logic [7:0] wdata, logic io);
    in_item_t t;
    t.req_type   = req;
    t.address    = addr;
    t.write_data = wdata;
    t.io_in      = io;
    return t;
  endfunction

  // Plain ticks; a few carry requests that the block must drop
  task automatic queue_ticks(int n, int io_sel, logic busy);
    int         i;
    logic [1:0] req;
    logic       io;
    for (i = 0; i < n; i++) begin
      req = REQ_TICK;
      if ($urandom_range(9) == 0) req = busy ? 2'($urandom_range(1, 3)) : REQ_UNUSED;
      io = (io_sel == IO_RANDOM) ? ($urandom_range(1) != 0) : (io_sel == IO_HIGH);
      tick_q.push_back(make_tick(req, 8'($urandom), 8'($urandom), io));
    end
  endtask

  // One full serial transfer: the request tick and exactly enough ticks to finish
  task automatic queue_transfer(logic [1:0] req, logic [7:0] addr, logic [7:0] wdata,
                                int io_sel);
    int eff;
    int span;
    eff  = (half_ticks == 8'd0) ? 1 : int'(half_ticks);
    span = ((req == REQ_WRITE) ? 33 : 31) * eff;
    tick_q.push_back(make_tick(req, addr, wdata, $urandom_range(1) != 0));
    queue_ticks(span, io_sel, 1'b1);
  endtask

  // Mostly complete transfers with random content, some idle noise between them
  task automatic queue_random_traffic(int n_items);
    int base;
    int pick;
    base = tick_q.size();
    while (tick_q.size() - base < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_transfer(REQ_WRITE, 8'($urandom), 8'($urandom), IO_RANDOM);
      end else if (pick < 90) begin
        queue_transfer(REQ_READ, 8'($urandom), 8'($urandom), IO_RANDOM);
      end else begin
        queue_ticks($urandom_range(1, 4), IO_RANDOM, 1'b0);
      end
      if ($urandom_range(1) == 0) queue_ticks($urandom_range(0, 2), IO_RANDOM, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || pin_levels_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drain, write the half period, then switch the idle mix
  task automatic run_phase(logic [7:0] half, int send_pct, int stall_pct);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= half;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    half_ticks = half;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Driver: predict each accepted tick, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pin_levels_q.push_back(advance_sequencer(in_data));
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_levels_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("result %0d arrived with no prediction pending", result_cnt);
        end else begin
          want = pin_levels_q.pop_front();
          if (out_data.chip_enable !== want.chip_enable ||
              out_data.serial_clock !== want.serial_clock ||
              out_data.io_out !== want.io_out ||
              out_data.io_drive !== want.io_drive ||
              out_data.busy_res !== want.busy_res ||
              out_data.done_res !== want.done_res ||
              out_data.read_data !== want.read_data) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT) begin
              $display("result %0d mismatch: exp ce=%b sclk=%b io=%b drv=%b busy=%b done=%b rd=%h",
                       result_cnt, want.chip_enable, want.serial_clock, want.io_out,
                       want.io_drive, want.busy_res, want.done_res, want.read_data);
              $display("  got ce=%b sclk=%b io=%b drv=%b busy=%b done=%b rd=%h",
                       out_data.chip_enable, out_data.serial_clock, out_data.io_out,
                       out_data.io_drive, out_data.busy_res, out_data.done_res,
                       out_data.read_data);
            end
          end
        end
        result_cnt++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("FAIL three_wire_rtc_serial_master");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // read started at the reset half period, cut short by a change to zero
    tick_q.push_back(make_tick(REQ_READ, 8'h5A, 8'hC3, 1'b0));
    queue_ticks(24, IO_RANDOM, 1'b1);
    run_phase(8'd0, IDLE_NONE, IDLE_NONE);
    // write request while the read is still running; the read ends on the last tick
    tick_q.push_back(make_tick(REQ_WRITE, 8'hFF, 8'hFF, 1'b1));
    queue_ticks(28, IO_RANDOM, 1'b1);
    // unused request code at idle
    tick_q.push_back(make_tick(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1));
    queue_transfer(REQ_WRITE, 8'h00, 8'hFF, IO_RANDOM);
    queue_transfer(REQ_READ, 8'h00, 8'h00, IO_LOW);
    // write data carried on a read must not matter
    queue_transfer(REQ_READ, 8'hFF, 8'hFF, IO_HIGH);
    // write completion keeps the last read byte
    queue_transfer(REQ_WRITE, 8'hFF, 8'h00, IO_RANDOM);

    run_phase(8'd1, IDLE_NONE, IDLE_NONE);
    queue_random_traffic(40);
    run_phase(8'd2, IDLE_ONE, IDLE_NONE);
    queue_random_traffic(40);
    run_phase(8'd1, IDLE_NONE, IDLE_ONE);
    queue_random_traffic(40);
    run_phase(8'd3, IDLE_BOTH, IDLE_BOTH);
    queue_random_traffic(40);

    // longest half period: hold a read past the end of its first clock level
    run_phase(8'd255, IDLE_BOTH, IDLE_BOTH);
    tick_q.push_back(make_tick(REQ_READ, 8'($urandom), 8'($urandom), 1'b1));
    queue_ticks(259, IO_RANDOM, 1'b1);
    run_phase(8'd1, IDLE_ONE, IDLE_NONE);
    queue_ticks(32, IO_RANDOM, 1'b1);

    run_phase(8'($urandom_range(2, 3)), IDLE_NONE, IDLE_NONE);
    queue_random_traffic(30);

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("PASS three_wire_rtc_serial_master");
    end else begin
      $display("FAIL three_wire_rtc_serial_master");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/twrtc_pkg.sv
hdl/three_wire_rtc_serial_master.sv
hdl/twrtc_checker.sv
tb/three_wire_rtc_serial_master_tb.sv
